// ===== src/swapchain_buffer_state_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Swapchain buffer state tracker: assertion macros
// Shared assertion forms for the tracker, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SWAPCHAIN_BUFFER_STATE_TRACKER_DEFINES_SVH
`define SWAPCHAIN_BUFFER_STATE_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCBST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCBST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/scbst_pkg.sv =====
// ----------------------------------------------------------------------------
// Swapchain buffer state tracker: package
// Types, codes and sizing constants shared by the tracker modules.
// ----------------------------------------------------------------------------
package scbst_pkg;

  // Number of buffer state entries held by the tracker.
  localparam int MAX_BUFFERS = 3;
  // Width of an entry index and of a buffer count.
  localparam int IDX_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int CNT_W = $clog2(MAX_BUFFERS + 1);
  // Width used to compare indexes against counts without loss.
  localparam int CMP_W = 8;
  // Fixed field widths of the channels.
  localparam int REQ_W = 3;
  localparam int BIDX_W = 2;
  localparam int BCNT_W = 2;
  localparam int TOT_W = 32;

  // Buffer lifecycle state.
  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_ACQ    = 2'd1,
    ST_QUEUED = 2'd2,
    ST_DISP   = 2'd3
  } buf_state_t;

  // Request codes; code 7 is unused.
  typedef enum logic [REQ_W-1:0] {
    REQ_ACQ_BACK  = 3'd0,
    REQ_PRESENT   = 3'd1,
    REQ_ACQ_DISP  = 3'd2,
    REQ_REL_DISP  = 3'd3,
    REQ_GET_FRONT = 3'd4,
    REQ_GET_BACK  = 3'd5,
    REQ_RESET     = 3'd6
  } req_code_t;

  // Result status codes.
  typedef enum logic [1:0] {
    RS_OK      = 2'd0,
    RS_INVALID = 2'd1,
    RS_FULL    = 2'd2,
    RS_EMPTY   = 2'd3
  } status_t;

  // One request item.
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BIDX_W-1:0] buffer_index;
  } req_item_t;

  // One result item.
  typedef struct packed {
    status_t           status;
    logic [BIDX_W-1:0] slot_id;
    logic [TOT_W-1:0]  acquire_total;
    logic [TOT_W-1:0]  queue_total;
    logic [TOT_W-1:0]  display_total;
    logic [TOT_W-1:0]  release_total;
  } rsp_item_t;

  // Reset value of the buffer count.
  localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(2);

endpackage

// ===== src/scbst_if.sv =====
// ----------------------------------------------------------------------------
// Swapchain buffer state tracker: channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface scbst_req_if;
  import scbst_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BIDX_W-1:0] buffer_index;

  modport source (output valid, output req_type, output buffer_index, input ready);
  modport sink (input valid, input req_type, input buffer_index, output ready);
endinterface

interface scbst_rsp_if;
  import scbst_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [BIDX_W-1:0] slot_id;
  logic [TOT_W-1:0]  acquire_total;
  logic [TOT_W-1:0]  queue_total;
  logic [TOT_W-1:0]  display_total;
  logic [TOT_W-1:0]  release_total;

  modport source (output valid, output status, output slot_id, output acquire_total,
                  output queue_total, output display_total, output release_total,
                  input ready);
  modport sink (input valid, input status, input slot_id, input acquire_total,
                input queue_total, input display_total, input release_total,
                output ready);
endinterface

// ===== src/scbst_engine.sv =====
// ----------------------------------------------------------------------------
// Swapchain buffer state tracker: request engine
// Holds the buffer states, active count and telemetry counters, and works out
// the result of one request combinationally.
// ----------------------------------------------------------------------------
module scbst_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  scbst_pkg::req_item_t         req,
  input  logic [scbst_pkg::BCNT_W-1:0] slot_count,
  output scbst_pkg::rsp_item_t         rsp
);
  import scbst_pkg::*;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } find_t;

  buf_state_t        state_r   [MAX_BUFFERS];
  buf_state_t        state_nxt [MAX_BUFFERS];
  logic [CNT_W-1:0]  active_r, active_nxt;
  logic [TOT_W-1:0]  acq_r, acq_nxt;
  logic [TOT_W-1:0]  que_r, que_nxt;
  logic [TOT_W-1:0]  dsp_r, dsp_nxt;
  logic [TOT_W-1:0]  rel_r, rel_nxt;
  logic              idx_ok;
  logic [IDX_W-1:0]  sel;
  find_t             f_free, f_acq, f_que, f_dsp;
  status_t           status;
  logic [IDX_W-1:0]  id;

  // Lowest entry below the active count that holds the given state.
  function automatic find_t find_lowest(input buf_state_t st_in [MAX_BUFFERS],
                                        input logic [CNT_W-1:0] act,
                                        input buf_state_t want);
    find_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int b = MAX_BUFFERS - 1; b >= 0; b--) begin
      if ((CMP_W'(b) < CMP_W'(act)) && (st_in[b] == want)) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(b);
      end
    end
    return r;
  endfunction

  // Count clamped to the supported range.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [BCNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (CMP_W'(v) < CMP_W'(2)) begin
      r = CNT_W'(2);
    end else if (CMP_W'(v) > CMP_W'(MAX_BUFFERS)) begin
      r = CNT_W'(MAX_BUFFERS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  // Priority searches over the active entries.
  always_comb begin
    f_free = find_lowest(state_r, active_r, ST_FREE);
    f_acq  = find_lowest(state_r, active_r, ST_ACQ);
    f_que  = find_lowest(state_r, active_r, ST_QUEUED);
    f_dsp  = find_lowest(state_r, active_r, ST_DISP);
  end

  // The named buffer must lie below the active count and within the store.
  assign idx_ok = (CMP_W'(req.buffer_index) < CMP_W'(active_r)) &&
                  (CMP_W'(req.buffer_index) < CMP_W'(MAX_BUFFERS));
  assign sel = IDX_W'(req.buffer_index);

  // Request decode and next state.
  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    acq_nxt    = acq_r;
    que_nxt    = que_r;
    dsp_nxt    = dsp_r;
    rel_nxt    = rel_r;
    status     = RS_OK;
    id         = '0;
    case (req.req_type)
      REQ_ACQ_BACK: begin
        if (!f_free.found) begin
          status = RS_FULL;
        end else begin
          state_nxt[f_free.idx] = ST_ACQ;
          acq_nxt = acq_r + TOT_W'(1);
          id = f_free.idx;
        end
      end
      REQ_PRESENT: begin
        if (!idx_ok || state_r[sel] != ST_ACQ) begin
          status = RS_INVALID;
        end else begin
          state_nxt[sel] = ST_QUEUED;
          que_nxt = que_r + TOT_W'(1);
          id = sel;
        end
      end
      REQ_ACQ_DISP: begin
        if (!f_que.found) begin
          status = RS_EMPTY;
        end else begin
          state_nxt[f_que.idx] = ST_DISP;
          dsp_nxt = dsp_r + TOT_W'(1);
          id = f_que.idx;
        end
      end
      REQ_REL_DISP: begin
        if (!idx_ok || state_r[sel] != ST_DISP) begin
          status = RS_INVALID;
        end else begin
          state_nxt[sel] = ST_FREE;
          rel_nxt = rel_r + TOT_W'(1);
          id = sel;
        end
      end
      REQ_GET_FRONT: begin
        if (!f_dsp.found) begin
          status = RS_INVALID;
        end else begin
          id = f_dsp.idx;
        end
      end
      REQ_GET_BACK: begin
        if (f_acq.found) begin
          id = f_acq.idx;
        end else if (f_free.found) begin
          id = f_free.idx;
        end else begin
          status = RS_INVALID;
        end
      end
      REQ_RESET: begin
        active_nxt = clamp_count(slot_count);
        for (int b = 0; b < MAX_BUFFERS; b++) begin
          state_nxt[b] = (b == 0) ? ST_DISP : ST_FREE;
        end
      end
      default: begin
        status = RS_INVALID;
      end
    endcase
  end

  // Result carries the counters as they stand after this request.
  always_comb begin
    rsp.status        = status;
    rsp.slot_id       = BIDX_W'(id);
    rsp.acquire_total = acq_nxt;
    rsp.queue_total   = que_nxt;
    rsp.display_total = dsp_nxt;
    rsp.release_total = rel_nxt;
  end

  // State and counter registers, updated once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < MAX_BUFFERS; b++) begin
        state_r[b] <= (b == 0) ? ST_DISP : ST_FREE;
      end
      active_r <= RESET_COUNT;
      acq_r    <= '0;
      que_r    <= '0;
      dsp_r    <= '0;
      rel_r    <= '0;
    end else if (fire) begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      acq_r    <= acq_nxt;
      que_r    <= que_nxt;
      dsp_r    <= dsp_nxt;
      rel_r    <= rel_nxt;
    end
  end

endmodule

// ===== src/scbst_out_stage.sv =====
// ----------------------------------------------------------------------------
// Swapchain buffer state tracker: result register
// Holds one finished result item until the result channel takes it.
// ----------------------------------------------------------------------------
module scbst_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  scbst_pkg::rsp_item_t rsp,
  output logic                 can_load,
  scbst_rsp_if.source          out_ch
);
  import scbst_pkg::*;

  logic      valid_r, valid_nxt;
  rsp_item_t rsp_r;

  // The register may take a new item when empty or when its item leaves now.
  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= rsp;
    end
  end

  // Drive the result channel.
  assign out_ch.valid         = valid_r;
  assign out_ch.status        = rsp_r.status;
  assign out_ch.slot_id       = rsp_r.slot_id;
  assign out_ch.acquire_total = rsp_r.acquire_total;
  assign out_ch.queue_total   = rsp_r.queue_total;
  assign out_ch.display_total = rsp_r.display_total;
  assign out_ch.release_total = rsp_r.release_total;

endmodule

// ===== src/swapchain_buffer_state_tracker.sv =====
// A request waits in the input register until the result register can take
// its result item. One item per cycle while the result channel is ready;
// the input and result registers let a new request enter while the previous
// result still waits on output. The engine reads and writes buffer states.
// Reset (rst_n low, synchronous): entry 0 displaying, others free, counters
// zero, buffer count and active count two, both channel registers empty.
// ----------------------------------------------------------------------------
// Swapchain buffer state tracker: top level
// Tracks free, acquired, queued and displaying frame buffers for double or
// triple buffering and reports telemetry counters with every result item.
// ----------------------------------------------------------------------------
`include "swapchain_buffer_state_tracker_defines.svh"

module swapchain_buffer_state_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  scbst_req_if.sink                    in_ch,
  scbst_rsp_if.source                  out_ch,
  input  logic                         cfg_wr_en,
  input  logic [scbst_pkg::BCNT_W-1:0] cfg_wr_data
);
  import scbst_pkg::*;

  logic              in_valid_r, in_valid_nxt;
  req_item_t         in_req_r;
  logic [BCNT_W-1:0] slot_count_r;
  logic              in_take;
  logic              advance;
  logic              can_load;
  rsp_item_t         rsp;
  logic              rsp_err;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= BCNT_W'(2);
    end else if (cfg_wr_en) begin
      slot_count_r <= cfg_wr_data;
    end
  end

  // Input register handshake: the held item moves on whenever the result
  // register can take its result.
  assign advance     = in_valid_r && can_load;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req_r.req_type     <= in_ch.req_type;
      in_req_r.buffer_index <= in_ch.buffer_index;
    end
  end

  // Request engine.
  scbst_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .req        (in_req_r),
    .slot_count (slot_count_r),
    .rsp        (rsp)
  );

  // Result register.
  scbst_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .rsp      (rsp),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  // An offered result that reports a failure.
  assign rsp_err = out_ch.valid && (out_ch.status != RS_OK);

  // A processed item always shows up on the result channel next cycle.
  `SCBST_ASSERT_NEXT(a_advance_gives_result, advance, out_ch.valid, "processed item lost")
  // A held request that cannot move on stays held.
  `SCBST_ASSERT_NEXT(a_input_holds, in_valid_r && !advance, in_valid_r, "held request dropped")
  // A failed request reports buffer 0.
  `SCBST_ASSERT_SAME(a_id_zero_on_error, rsp_err, out_ch.slot_id == '0, "non-zero id on error")

endmodule
